// ===== rtl/tsp_pkg.sv =====
// Types, constants and helper functions shared by the timed sample pattern player.
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int TIME_BITS   = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 11;
  localparam int INDEX_W     = 10;
  localparam int LEVEL_W     = 16;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_LOAD    = 2'd1;
  localparam logic [1:0] ACT_START   = 2'd2;
  localparam logic [1:0] ACT_RESTART = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITAL_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 3'd5;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_LOAD,
    CMD_PLAY,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]                action;
    logic [INDEX_W-1:0]        sample_index;
    logic [31:0]               sample_time;
    logic signed [LEVEL_W-1:0] sample_level;
    logic [31:0]               restart_base;
  } in_beat_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic                      transition;
    logic                      active;
    logic                      wrapped;
  } out_beat_t;

  typedef struct packed {
    logic [31:0]               repeat_period;
    logic [31:0]               start_offset;
    logic                      digital_mode;
    logic signed [LEVEL_W-1:0] high_level;
    logic signed [LEVEL_W-1:0] initial_level;
    logic [CNT_W-1:0]          sample_count;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e                 kind;
    logic [ADDR_W-1:0]         addr;
    logic [TIME_BITS-1:0]      value;
    logic signed [LEVEL_W-1:0] level;
  } cmd_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [TIME_BITS-1:0] wtime;
    logic [LEVEL_W-1:0]   wlevel;
    logic                 re;
    logic [ADDR_W-1:0]    time_raddr;
    logic [ADDR_W-1:0]    level_raddr;
  } ram_req_t;

  function automatic logic signed [LEVEL_W-1:0] map_level(
    input logic signed [LEVEL_W-1:0] v,
    input logic                      digital,
    input logic signed [LEVEL_W-1:0] high
  );
    if (digital) begin
      return (v > 0) ? high : '0;
    end
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    return (c > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tsp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/tsp_front.sv =====
// Front end: takes input beats and classifies them into player commands.
`timescale 1ns / 1ps
`default_nettype none

module tsp_front import tsp_pkg::*; (
  input  wire logic             in_valid_i,
  input  wire in_beat_t         in_beat_i,
  output logic                  in_stall_o,
  input  wire cfg_t             cfg_i,
  input  wire logic [CNT_W-1:0] cnt_i,
  input  wire logic             q_full_i,
  output logic                  push_valid_o,
  output cmd_t                  push_cmd_o
);

  always_comb begin
    push_cmd_o.addr  = in_beat_i.sample_index[ADDR_W-1:0];
    push_cmd_o.level = in_beat_i.sample_level;
    push_cmd_o.value = in_beat_i.sample_time;
    push_cmd_o.kind  = CMD_NOP;
    unique case (in_beat_i.action)
      ACT_TICK: begin
        push_cmd_o.kind = CMD_TICK;
      end
      ACT_LOAD: begin
        if (CNT_W'(in_beat_i.sample_index) < CNT_W'(TABLE_DEPTH)) begin
          push_cmd_o.kind = CMD_LOAD;
        end
      end
      ACT_START: begin
        push_cmd_o.value = cfg_i.start_offset;
        if (cnt_i != '0) begin
          push_cmd_o.kind = CMD_PLAY;
        end
      end
      ACT_RESTART: begin
        push_cmd_o.value = in_beat_i.restart_base;
        if (cnt_i != '0) begin
          push_cmd_o.kind = CMD_PLAY;
        end
      end
      default: begin
        push_cmd_o.kind = CMD_NOP;
      end
    endcase
  end

  assign push_valid_o = in_valid_i;
  assign in_stall_o   = q_full_i;

endmodule

`default_nettype wire

// ===== rtl/tsp_queue.sv =====
// Short command queue between the front end and the playback engine.
`timescale 1ns / 1ps
`default_nettype none

module tsp_queue import tsp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  input  wire cmd_t push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign push    = push_valid_i && !full_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tsp_back.sv =====
// Playback engine: tick counter, schedule state, table access and output register.
`timescale 1ns / 1ps
`default_nettype none

module tsp_back import tsp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_valid_i,
  input  wire cmd_t                 q_cmd_i,
  output logic                      q_pop_o,
  input  wire cfg_t                 cfg_i,
  input  wire logic [CNT_W-1:0]     cnt_i,
  output ram_req_t                  ram_req_o,
  input  wire logic [TIME_BITS-1:0] time_rdata_i,
  input  wire logic [LEVEL_W-1:0]   level_rdata_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_beat_t                 out_beat_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHANGE = 2'd1;
  localparam logic [1:0] ST_START  = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [TIME_BITS-1:0]      tick_q, tick_d;
  logic [ADDR_W-1:0]         pi_q, pi_d;
  logic [TIME_BITS-1:0]      base_q, base_d;
  logic [TIME_BITS-1:0]      next_q, next_d;
  logic signed [LEVEL_W-1:0] level_q, level_d;
  logic                      running_q, running_d;
  logic                      stop_q, stop_d;
  logic                      wrap_q, wrap_d;
  logic                      out_valid_q, out_valid_d;
  out_beat_t                 out_q, out_d;
  logic                      out_free;
  logic [TIME_BITS-1:0]      tick_inc;
  logic [ADDR_W:0]           pi_inc;
  logic [TIME_BITS-1:0]      nc;

  assign out_free = !out_valid_q || !out_stall_i;
  assign tick_inc = tick_q + 1'b1;
  assign pi_inc   = {1'b0, pi_q} + 1'b1;
  assign nc       = time_rdata_i + base_q;

  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    pi_d        = pi_q;
    base_d      = base_q;
    next_d      = next_q;
    level_d     = level_q;
    running_d   = running_q;
    stop_d      = stop_q;
    wrap_d      = wrap_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    q_pop_o     = 1'b0;
    ram_req_o   = '0;
    ram_req_o.waddr  = q_cmd_i.addr;
    ram_req_o.wtime  = q_cmd_i.value;
    ram_req_o.wlevel = q_cmd_i.level;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.kind)
            CMD_TICK: begin
              tick_d = tick_inc;
              if (running_q && (tick_inc == next_q)) begin
                ram_req_o.re          = 1'b1;
                ram_req_o.level_raddr = pi_q;
                stop_d = 1'b0;
                wrap_d = 1'b0;
                if (CNT_W'(pi_inc) >= cnt_i) begin
                  pi_d = '0;
                  if ((cfg_i.repeat_period == '0) || (cnt_i == '0)) begin
                    running_d = 1'b0;
                    stop_d    = 1'b1;
                  end else begin
                    base_d = base_q + cfg_i.repeat_period;
                    wrap_d = 1'b1;
                  end
                end else begin
                  pi_d = pi_inc[ADDR_W-1:0];
                end
                ram_req_o.time_raddr = pi_d;
                state_d = ST_CHANGE;
              end else begin
                out_valid_d      = 1'b1;
                out_d.level      = level_q;
                out_d.transition = 1'b0;
                out_d.active     = running_q;
                out_d.wrapped    = 1'b0;
              end
            end
            CMD_LOAD: begin
              ram_req_o.we     = 1'b1;
              out_valid_d      = 1'b1;
              out_d.level      = level_q;
              out_d.transition = 1'b0;
              out_d.active     = running_q;
              out_d.wrapped    = 1'b0;
            end
            CMD_PLAY: begin
              ram_req_o.re          = 1'b1;
              ram_req_o.time_raddr  = '0;
              ram_req_o.level_raddr = '0;
              base_d    = q_cmd_i.value;
              pi_d      = '0;
              level_d   = map_level(cfg_i.initial_level, cfg_i.digital_mode,
                                    cfg_i.high_level);
              running_d = 1'b1;
              state_d   = ST_START;
            end
            default: begin
              out_valid_d      = 1'b1;
              out_d.level      = level_q;
              out_d.transition = 1'b0;
              out_d.active     = running_q;
              out_d.wrapped    = 1'b0;
            end
          endcase
        end
      end
      ST_CHANGE: begin
        if (out_free) begin
          level_d = map_level(signed'(level_rdata_i), cfg_i.digital_mode,
                              cfg_i.high_level);
          if (!stop_q) begin
            next_d = (nc <= tick_q) ? tick_inc : nc;
          end
          out_valid_d      = 1'b1;
          out_d.level      = level_d;
          out_d.transition = 1'b1;
          out_d.active     = running_q;
          out_d.wrapped    = wrap_q;
          state_d          = ST_IDLE;
        end
      end
      ST_START: begin
        if (out_free) begin
          next_d           = nc;
          out_valid_d      = 1'b1;
          out_d.level      = level_q;
          out_d.transition = 1'b0;
          out_d.active     = running_q;
          out_d.wrapped    = 1'b0;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      pi_q        <= '0;
      base_q      <= '0;
      next_q      <= '0;
      level_q     <= '0;
      running_q   <= 1'b0;
      stop_q      <= 1'b0;
      wrap_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      pi_q        <= pi_d;
      base_q      <= base_d;
      next_q      <= next_d;
      level_q     <= level_d;
      running_q   <= running_d;
      stop_q      <= stop_d;
      wrap_q      <= wrap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`ifndef NO_ASSERTIONS
  a_pop_yields_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (out_valid_q || (state_q != ST_IDLE)))
    else $error("Command popped without a pending result or a busy engine.");

  a_finish_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != ST_IDLE) && out_free) |=> (state_q == ST_IDLE))
    else $error("Engine did not finish a two-cycle command.");

  a_start_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_START) |-> running_q)
    else $error("Start in progress without the player running.");

  a_stop_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CHANGE) && stop_q) |-> !running_q)
    else $error("End of table reached but the player is still running.");

  a_wrap_is_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.wrapped) |-> (out_q.transition && out_q.active))
    else $error("Wrap reported without a sample change.");
`endif

endmodule

`default_nettype wire

// ===== rtl/timed_sample_pattern_player_unit.sv =====
// Top level of the timed sample pattern player: configuration, queue, engine and tables.
`timescale 1ns / 1ps
`default_nettype none

// Each beat on the input produces exactly one result beat. A tick that reaches no
// scheduled change, a sample load and a start with an empty table are done in the
// engine's ST_IDLE; a tick at which a sample takes effect, and a start or restart, go
// on to ST_CHANGE or ST_START, because the engine waits for the registered read of the
// time and level table RAMs. A two-beat command queue lets the input keep flowing while
// the engine works or the output is stalled. The tables need no clearing after reset.
module timed_sample_pattern_player_unit import tsp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_beat_t             in_beat_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_beat_t                 out_beat_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t                 cfg_q;
  logic [CNT_W-1:0]     cnt;
  logic                 push_valid;
  cmd_t                 push_cmd;
  logic                 q_full;
  logic                 q_valid;
  cmd_t                 q_cmd;
  logic                 q_pop;
  ram_req_t             ram_req;
  logic [TIME_BITS-1:0] time_rdata;
  logic [LEVEL_W-1:0]   level_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_period <= '0;
      cfg_q.start_offset  <= '0;
      cfg_q.digital_mode  <= 1'b0;
      cfg_q.high_level    <= 16'sd5000;
      cfg_q.initial_level <= '0;
      cfg_q.sample_count  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_REPEAT_PERIOD: cfg_q.repeat_period <= cfg_data_i;
        REG_START_OFFSET:  cfg_q.start_offset  <= cfg_data_i;
        REG_DIGITAL_MODE:  cfg_q.digital_mode  <= cfg_data_i[0];
        REG_HIGH_LEVEL:    cfg_q.high_level    <= signed'(cfg_data_i[LEVEL_W-1:0]);
        REG_INITIAL_LEVEL: cfg_q.initial_level <= signed'(cfg_data_i[LEVEL_W-1:0]);
        REG_SAMPLE_COUNT:  cfg_q.sample_count  <= cfg_data_i[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cnt = eff_count(cfg_q.sample_count);

  tsp_front u_front (
    .in_valid_i   (in_valid_i),
    .in_beat_i    (in_beat_i),
    .in_stall_o   (in_stall_o),
    .cfg_i        (cfg_q),
    .cnt_i        (cnt),
    .q_full_i     (q_full),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd)
  );

  tsp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .cmd_o        (q_cmd)
  );

  tsp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd),
    .q_pop_o       (q_pop),
    .cfg_i         (cfg_q),
    .cnt_i         (cnt),
    .ram_req_o     (ram_req),
    .time_rdata_i  (time_rdata),
    .level_rdata_i (level_rdata),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_beat_o    (out_beat_o)
  );

  tsp_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wtime),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.time_raddr),
    .rdata_o (time_rdata)
  );

  tsp_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wlevel),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.level_raddr),
    .rdata_o (level_rdata)
  );

endmodule

`default_nettype wire
